/* rtl/core/lfd_pkg.sv */
// Shared types, constants and constant functions of the link flap damper.
package lfd_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DIV_W = 64;
  localparam int unsigned MUL_W = 33;
  localparam logic [6:0] DIV_STEPS = 7'd64;
  localparam logic [32:0] US_PER_MS = 33'd1000;

  localparam logic [1:0] ST_UNKNOWN = 2'd0;
  localparam logic [1:0] ST_UP = 2'd1;
  localparam logic [1:0] ST_DOWN = 2'd2;

  localparam logic [1:0] K_LINK = 2'd0;
  localparam logic [1:0] K_TIME = 2'd1;
  localparam logic [1:0] K_RESTART = 2'd2;

  localparam logic [2:0] REG_MAX = 3'd0;
  localparam logic [2:0] REG_HL = 3'd1;
  localparam logic [2:0] REG_SUP = 3'd2;
  localparam logic [2:0] REG_REUSE = 3'd3;
  localparam logic [2:0] REG_FLAP = 3'd4;
  localparam logic [2:0] REG_MON = 3'd5;

  typedef struct packed {
    logic start;
    logic [6:0] steps;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
    logic [DIV_W-1:0] rem0;
  } div_cmd_t;

  typedef struct packed {
    logic done;
    logic [DIV_W-1:0] quo;
    logic [DIV_W-1:0] rem;
  } div_sts_t;

  // k-th repeated floored Q31 square root of 2, evaluated at elaboration only.
  function automatic logic [32:0] lfd_root(input int unsigned k);
    logic [63:0] r;
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bit_v;
    r = 64'd1 << 32;
    for (int unsigned i = 0; i < k; i++) begin
      n = r << 31;
      res = 64'd0;
      bit_v = 64'd1 << 62;
      for (int unsigned j = 0; j < 32; j++) begin
        if (n >= res + bit_v) begin
          n = n - (res + bit_v);
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
      r = res;
    end
    return r[32:0];
  endfunction

endpackage

/* rtl/core/lfd_div.sv */
// Shared restoring divider that retires one quotient bit per cycle.
module lfd_div import lfd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_cmd_t cmd,
  output div_sts_t sts
);

  logic [DIV_W-1:0] n_r;
  logic [DIV_W-1:0] r_r;
  logic [DIV_W-1:0] q_r;
  logic [DIV_W-1:0] d_r;
  logic [6:0] cnt_r;
  logic busy_r;
  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic fits;

  assign trial = {r_r, n_r[DIV_W-1]};
  assign diff = trial - {1'b0, d_r};
  assign fits = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= 7'd0;
    end else if (cmd.start) begin
      busy_r <= 1'b1;
      cnt_r <= cmd.steps;
    end else if (busy_r) begin
      busy_r <= (cnt_r != 7'd1);
      cnt_r <= cnt_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      n_r <= cmd.num;
      r_r <= cmd.rem0;
      q_r <= '0;
      d_r <= cmd.den;
    end else if (busy_r) begin
      n_r <= {n_r[DIV_W-2:0], 1'b0};
      r_r <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      q_r <= {q_r[DIV_W-2:0], fits};
    end
  end

  assign sts.done = busy_r && (cnt_r == 7'd1);
  assign sts.quo = q_r;
  assign sts.rem = r_r;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> !busy_r) else $error("divider started while busy");
  a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (cnt_r != 7'd0)) else $error("divider count and busy disagree");
  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |=> !busy_r) else $error("divider still busy after done");
`endif

endmodule

/* rtl/core/lfd_mul.sv */
// Shared registered 33 by 33 bit multiplier.
module lfd_mul import lfd_pkg::*; (
  input  logic               clk,
  input  logic [MUL_W-1:0]   a,
  input  logic [MUL_W-1:0]   b,
  output logic [2*MUL_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= {{MUL_W{1'b0}}, a} * {{MUL_W{1'b0}}, b};
  end

endmodule

/* rtl/core/link_flap_damper_top.sv */
// Top level of the link flap damper: sequencer, state and configuration port.
// The damper accepts one request at a time and answers each with exactly one result. A link-up,
// an unused kind, an unchanged restart or a time check before its deadline goes straight to the
// done state. While damping is enabled, a link-down with a nonzero penalty decays the penalty to
// the request's time through the shared divider and multiplier (two 64-bit divisions, one
// fraction division of FRAC_BITS steps and FRAC_BITS multiplies); arming a reuse deadline adds
// a log2 search of up to 32 steps, a 64-bit division, FRAC_BITS squarings and four multiplies.
// A restart that applies new settings and enables damping goes on to compute the penalty
// ceiling. A finished result waits in the output register while the next request is accepted.
// Settings are written at word addresses through the APB port and take effect at a restart.
module link_flap_damper_top import lfd_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic              in_link_up,
  input  logic [63:0]       in_now_us,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_notify,
  output logic [1:0]        out_advertised_state,
  output logic              out_suppressing,
  output logic [31:0]       out_penalty,
  output logic              out_timer_armed,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned CW = $clog2(FRAC_BITS);

  typedef enum logic [23:0] {
    S_IDLE     = 24'h000001,
    S_DT_DIV   = 24'h000002,
    S_WHOLE    = 24'h000004,
    S_FRAC_DIV = 24'h000008,
    S_POW_MUL  = 24'h000010,
    S_POW_ACC  = 24'h000020,
    S_X_DIV    = 24'h000040,
    S_X_FIN    = 24'h000080,
    S_APPLY    = 24'h000100,
    S_POST     = 24'h000200,
    S_N_LOOP   = 24'h000400,
    S_LOG_DIV  = 24'h000800,
    S_LOG_LD   = 24'h001000,
    S_LOG_MUL  = 24'h002000,
    S_LOG_ACC  = 24'h004000,
    S_T_MUL    = 24'h008000,
    S_T_ACC    = 24'h010000,
    S_DEADLINE = 24'h020000,
    S_HL_MUL   = 24'h040000,
    S_HL_ACC   = 24'h080000,
    S_CEIL_DIV = 24'h100000,
    S_CEIL_MUL = 24'h200000,
    S_CEIL_ACC = 24'h400000,
    S_DONE     = 24'h800000
  } state_t;

  // What follows the decay: nothing, a suppress check, or a reuse check.
  typedef enum logic [1:0] {
    P_NONE  = 2'd0,
    P_SUP   = 2'd1,
    P_REUSE = 2'd2
  } post_t;

  // Written settings and the running copy that a restart loads.
  logic [31:0] cfg_max_r, cfg_hl_r, cfg_sup_r, cfg_reuse_r, cfg_flap_r;
  logic [31:0] cfg_max_nxt, cfg_hl_nxt, cfg_sup_nxt, cfg_reuse_nxt, cfg_flap_nxt;
  logic cfg_mon_r, cfg_mon_nxt;
  logic [31:0] run_max_r, run_hl_r, run_sup_r, run_reuse_r, run_flap_r;
  logic [31:0] run_max_nxt, run_hl_nxt, run_sup_nxt, run_reuse_nxt, run_flap_nxt;
  logic run_mon_r, run_mon_nxt;

  // Damper state.
  logic [1:0] actual_r, actual_nxt, shown_r, shown_nxt;
  logic [31:0] pen_r, pen_nxt, ceil_r, ceil_nxt;
  logic [63:0] last_r, last_nxt, deadline_r, deadline_nxt;
  logic damp_r, damp_nxt, pend_r, pend_nxt, en_r, en_nxt;
  logic [41:0] hl_us_r, hl_us_nxt;

  // Sequencer and working registers.
  state_t state_r, state_nxt;
  logic go_r, go_nxt;
  post_t post_r, post_nxt;
  logic [63:0] now_r, now_nxt, dt_r, dt_nxt, t_r, t_nxt;
  logic add_flap_r, add_flap_nxt, ceil_mode_r, ceil_mode_nxt, notify_r, notify_nxt;
  logic [4:0] whole_r, whole_nxt, n_r, n_nxt;
  logic [32:0] acc_r, acc_nxt, x_r, x_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [FRAC_BITS-1:0] lf_r, lf_nxt;
  logic [1:0] m_r, m_nxt;

  // Result register.
  logic out_valid_r, out_valid_nxt;
  logic o_notify_r, o_sup_r, o_arm_r;
  logic [1:0] o_adv_r;
  logic [31:0] o_pen_r;

  div_cmd_t div_cmd;
  div_sts_t div_sts;
  logic [MUL_W-1:0] mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_p;
  logic [32:0] root_tab [FRAC_BITS];
  logic cfg_wr;

  // Q31 roots of two, indexed by the fraction bit that selects them.
  for (genvar g = 0; g < FRAC_BITS; g++) begin : g_root
    localparam logic [32:0] RootK = lfd_root(FRAC_BITS - g);
    assign root_tab[g] = RootK;
  end

  lfd_div u_div (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(div_cmd),
    .sts(div_sts)
  );

  lfd_mul u_mul (
    .clk(clk),
    .a(mul_a),
    .b(mul_b),
    .prod_r(mul_p)
  );

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_notify = o_notify_r;
  assign out_advertised_state = o_adv_r;
  assign out_suppressing = o_sup_r;
  assign out_penalty = o_pen_r;
  assign out_timer_armed = o_arm_r;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[ADDR_W-1:2])
      REG_MAX:   prdata = cfg_max_r;
      REG_HL:    prdata = cfg_hl_r;
      REG_SUP:   prdata = cfg_sup_r;
      REG_REUSE: prdata = cfg_reuse_r;
      REG_FLAP:  prdata = cfg_flap_r;
      REG_MON:   prdata = {31'd0, cfg_mon_r};
      default:   prdata = 32'd0;
    endcase
  end

  // Divider operands follow the state that runs the division.
  always_comb begin
    div_cmd.start = go_r;
    div_cmd.steps = DIV_STEPS;
    div_cmd.num = 64'd0;
    div_cmd.den = 64'd1;
    div_cmd.rem0 = 64'd0;
    case (state_r)
      S_DT_DIV: begin
        div_cmd.num = dt_r;
        div_cmd.den = {22'd0, hl_us_r};
      end
      S_FRAC_DIV: begin
        div_cmd.steps = 7'(FRAC_BITS);
        div_cmd.rem0 = div_sts.rem;
        div_cmd.den = ceil_mode_r ? {32'd0, run_hl_r} : {22'd0, hl_us_r};
      end
      S_X_DIV: begin
        div_cmd.num = {1'b0, pen_r, 31'd0};
        div_cmd.den = {31'd0, acc_r};
      end
      S_CEIL_DIV: begin
        div_cmd.num = {32'd0, run_max_r};
        div_cmd.den = {32'd0, run_hl_r};
      end
      S_LOG_DIV: begin
        div_cmd.num = {1'b0, pen_r, 31'd0};
        div_cmd.den = {32'd0, run_reuse_r} << n_r;
      end
      default: ;
    endcase
  end

  // Multiplier operands follow the state that issues the product.
  always_comb begin
    mul_a = acc_r;
    mul_b = root_tab[j_r];
    case (state_r)
      S_LOG_MUL: begin
        mul_a = x_r;
        mul_b = x_r;
      end
      S_T_MUL: begin
        mul_a = m_r[0] ? 33'(hl_us_r[41:32]) : {1'b0, hl_us_r[31:0]};
        mul_b = m_r[1] ? 33'(n_r) : 33'(lf_r);
      end
      S_HL_MUL: begin
        mul_a = {1'b0, run_hl_r};
        mul_b = US_PER_MS;
      end
      S_CEIL_MUL: begin
        mul_a = {1'b0, run_reuse_r};
        mul_b = acc_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    logic [1:0] st_link;
    logic start_decay;
    logic changed;
    logic [32:0] sum33;
    logic [63:0] sh;
    logic [63:0] xq;
    logic [34:0] sq;
    logic big;
    logic [65:0] cval;
    logic [64:0] dsum;

    cfg_max_nxt = cfg_max_r;
    cfg_hl_nxt = cfg_hl_r;
    cfg_sup_nxt = cfg_sup_r;
    cfg_reuse_nxt = cfg_reuse_r;
    cfg_flap_nxt = cfg_flap_r;
    cfg_mon_nxt = cfg_mon_r;
    run_max_nxt = run_max_r;
    run_hl_nxt = run_hl_r;
    run_sup_nxt = run_sup_r;
    run_reuse_nxt = run_reuse_r;
    run_flap_nxt = run_flap_r;
    run_mon_nxt = run_mon_r;
    actual_nxt = actual_r;
    shown_nxt = shown_r;
    pen_nxt = pen_r;
    ceil_nxt = ceil_r;
    last_nxt = last_r;
    deadline_nxt = deadline_r;
    damp_nxt = damp_r;
    pend_nxt = pend_r;
    en_nxt = en_r;
    hl_us_nxt = hl_us_r;
    state_nxt = state_r;
    go_nxt = 1'b0;
    post_nxt = post_r;
    now_nxt = now_r;
    dt_nxt = dt_r;
    t_nxt = t_r;
    add_flap_nxt = add_flap_r;
    ceil_mode_nxt = ceil_mode_r;
    notify_nxt = notify_r;
    whole_nxt = whole_r;
    n_nxt = n_r;
    acc_nxt = acc_r;
    x_nxt = x_r;
    j_nxt = j_r;
    lf_nxt = lf_r;
    m_nxt = m_r;
    out_valid_nxt = out_valid_r && !out_ready;

    st_link = in_link_up ? ST_UP : ST_DOWN;
    start_decay = 1'b0;
    changed = (cfg_max_r != run_max_r) || (cfg_hl_r != run_hl_r) ||
              (cfg_sup_r != run_sup_r) || (cfg_reuse_r != run_reuse_r) ||
              (cfg_flap_r != run_flap_r) || (cfg_mon_r != run_mon_r);
    sum33 = {1'b0, pen_r} + {1'b0, run_flap_r};
    sh = {32'd0, run_reuse_r} << ({1'b0, n_r} + 6'd1);
    xq = div_sts.quo >> whole_r;
    sq = mul_p[65:31];
    big = (sq[34:32] != 3'd0);
    cval = mul_p >> (5'd31 - whole_r);
    dsum = {1'b0, now_r} + {1'b0, t_r};

    if (cfg_wr) begin
      case (paddr[ADDR_W-1:2])
        REG_MAX:   cfg_max_nxt = pwdata;
        REG_HL:    cfg_hl_nxt = pwdata;
        REG_SUP:   cfg_sup_nxt = pwdata;
        REG_REUSE: cfg_reuse_nxt = pwdata;
        REG_FLAP:  cfg_flap_nxt = pwdata;
        REG_MON:   cfg_mon_nxt = pwdata[0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          now_nxt = in_now_us;
          notify_nxt = 1'b0;
          add_flap_nxt = 1'b0;
          post_nxt = P_NONE;
          ceil_mode_nxt = 1'b0;
          state_nxt = S_DONE;
          case (in_kind)
            K_LINK: begin
              actual_nxt = st_link;
              if (!en_r || run_mon_r || !damp_r) begin
                if (st_link != shown_r) begin
                  shown_nxt = st_link;
                  notify_nxt = 1'b1;
                end
                if (en_r && !in_link_up) begin
                  add_flap_nxt = 1'b1;
                  post_nxt = run_mon_r ? P_NONE : P_SUP;
                  start_decay = 1'b1;
                end
              end else if (!in_link_up) begin
                pend_nxt = 1'b0;
                add_flap_nxt = 1'b1;
                post_nxt = P_REUSE;
                start_decay = 1'b1;
              end
            end
            K_TIME: begin
              if (pend_r && (in_now_us >= deadline_r)) begin
                pend_nxt = 1'b0;
                post_nxt = P_REUSE;
                start_decay = 1'b1;
              end
            end
            K_RESTART: begin
              if (changed) begin
                run_max_nxt = cfg_max_r;
                run_hl_nxt = cfg_hl_r;
                run_sup_nxt = cfg_sup_r;
                run_reuse_nxt = cfg_reuse_r;
                run_flap_nxt = cfg_flap_r;
                run_mon_nxt = cfg_mon_r;
                pen_nxt = 32'd0;
                damp_nxt = 1'b0;
                last_nxt = in_now_us;
                pend_nxt = 1'b0;
                if (actual_r != shown_r) begin
                  shown_nxt = actual_r;
                  notify_nxt = 1'b1;
                end
                if ((cfg_max_r == 32'd0) || (cfg_hl_r == 32'd0) || (cfg_sup_r == 32'd0) ||
                    (cfg_reuse_r == 32'd0) || (cfg_flap_r == 32'd0)) begin
                  ceil_nxt = 32'd0;
                  en_nxt = 1'b0;
                end else begin
                  en_nxt = 1'b1;
                  ceil_mode_nxt = 1'b1;
                  state_nxt = S_HL_MUL;
                end
              end
            end
            default: ;
          endcase
          if (start_decay) begin
            last_nxt = in_now_us;
            dt_nxt = (in_now_us >= last_r) ? (in_now_us - last_r) : 64'd0;
            if (pen_r == 32'd0) begin
              state_nxt = S_APPLY;
            end else begin
              state_nxt = S_DT_DIV;
              go_nxt = 1'b1;
            end
          end
        end
      end
      S_DT_DIV, S_CEIL_DIV: begin
        if (div_sts.done) begin
          state_nxt = S_WHOLE;
        end
      end
      S_WHOLE: begin
        if (div_sts.quo[63:5] != 59'd0) begin
          if (ceil_mode_r) begin
            ceil_nxt = 32'hFFFF_FFFF;
            state_nxt = S_DONE;
          end else begin
            pen_nxt = 32'd0;
            state_nxt = S_APPLY;
          end
        end else begin
          whole_nxt = div_sts.quo[4:0];
          state_nxt = S_FRAC_DIV;
          go_nxt = 1'b1;
        end
      end
      S_FRAC_DIV: begin
        if (div_sts.done) begin
          acc_nxt = 33'd1 << 31;
          j_nxt = CW'(FRAC_BITS - 1);
          state_nxt = S_POW_MUL;
        end
      end
      S_POW_MUL: begin
        state_nxt = S_POW_ACC;
      end
      S_POW_ACC: begin
        if (div_sts.quo[j_r]) begin
          acc_nxt = mul_p[63:31];
        end
        if (j_r == '0) begin
          if (ceil_mode_r) begin
            state_nxt = S_CEIL_MUL;
          end else begin
            state_nxt = S_X_DIV;
            go_nxt = 1'b1;
          end
        end else begin
          j_nxt = j_r - 1'b1;
          state_nxt = S_POW_MUL;
        end
      end
      S_X_DIV: begin
        if (div_sts.done) begin
          state_nxt = S_X_FIN;
        end
      end
      S_X_FIN: begin
        pen_nxt = xq[31:0];
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (add_flap_r) begin
          pen_nxt = (sum33 < {1'b0, ceil_r}) ? sum33[31:0] : ceil_r;
        end
        state_nxt = S_POST;
      end
      S_POST: begin
        state_nxt = S_DONE;
        case (post_r)
          P_SUP: begin
            if (pen_r >= run_sup_r) begin
              damp_nxt = 1'b1;
              if (pen_r <= run_reuse_r) begin
                t_nxt = 64'd0;
                state_nxt = S_DEADLINE;
              end else begin
                n_nxt = 5'd0;
                state_nxt = S_N_LOOP;
              end
            end
          end
          P_REUSE: begin
            if (pen_r <= run_reuse_r) begin
              damp_nxt = 1'b0;
              if (actual_r != shown_r) begin
                shown_nxt = actual_r;
                notify_nxt = 1'b1;
              end
            end else begin
              n_nxt = 5'd0;
              state_nxt = S_N_LOOP;
            end
          end
          default: ;
        endcase
      end
      S_N_LOOP: begin
        if (sh <= {32'd0, pen_r}) begin
          n_nxt = n_r + 5'd1;
        end else begin
          state_nxt = S_LOG_DIV;
          go_nxt = 1'b1;
        end
      end
      S_LOG_DIV: begin
        if (div_sts.done) begin
          state_nxt = S_LOG_LD;
        end
      end
      S_LOG_LD: begin
        x_nxt = div_sts.quo[32:0];
        lf_nxt = '0;
        j_nxt = CW'(FRAC_BITS - 1);
        state_nxt = S_LOG_MUL;
      end
      S_LOG_MUL: begin
        state_nxt = S_LOG_ACC;
      end
      S_LOG_ACC: begin
        lf_nxt = {lf_r[FRAC_BITS-2:0], big};
        x_nxt = big ? sq[33:1] : sq[32:0];
        if (j_r == '0) begin
          t_nxt = 64'd0;
          m_nxt = 2'd0;
          state_nxt = S_T_MUL;
        end else begin
          j_nxt = j_r - 1'b1;
          state_nxt = S_LOG_MUL;
        end
      end
      S_T_MUL: begin
        state_nxt = S_T_ACC;
      end
      S_T_ACC: begin
        // Wait = hl*n + floor(hl*logfrac / 2^F), built from the low 32 bits and high 10 bits of hl.
        case (m_r)
          2'd0:    t_nxt = t_r + (mul_p[63:0] >> FRAC_BITS);
          2'd1:    t_nxt = t_r + (mul_p[63:0] << (32 - FRAC_BITS));
          2'd2:    t_nxt = t_r + mul_p[63:0];
          default: t_nxt = t_r + {mul_p[31:0], 32'd0};
        endcase
        if (m_r == 2'd3) begin
          state_nxt = S_DEADLINE;
        end else begin
          m_nxt = m_r + 2'd1;
          state_nxt = S_T_MUL;
        end
      end
      S_DEADLINE: begin
        deadline_nxt = dsum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : dsum[63:0];
        pend_nxt = 1'b1;
        state_nxt = S_DONE;
      end
      S_HL_MUL: begin
        state_nxt = S_HL_ACC;
      end
      S_HL_ACC: begin
        hl_us_nxt = mul_p[41:0];
        state_nxt = S_CEIL_DIV;
        go_nxt = 1'b1;
      end
      S_CEIL_MUL: begin
        state_nxt = S_CEIL_ACC;
      end
      S_CEIL_ACC: begin
        ceil_nxt = (cval[65:32] != 34'd0) ? 32'hFFFF_FFFF : cval[31:0];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      go_r <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_max_r <= 32'd0;
      cfg_hl_r <= 32'd0;
      cfg_sup_r <= 32'd0;
      cfg_reuse_r <= 32'd0;
      cfg_flap_r <= 32'd0;
      cfg_mon_r <= 1'b0;
      run_max_r <= 32'd0;
      run_hl_r <= 32'd0;
      run_sup_r <= 32'd0;
      run_reuse_r <= 32'd0;
      run_flap_r <= 32'd0;
      run_mon_r <= 1'b0;
      actual_r <= ST_UNKNOWN;
      shown_r <= ST_UNKNOWN;
      pen_r <= 32'd0;
      ceil_r <= 32'd0;
      last_r <= 64'd0;
      deadline_r <= 64'd0;
      damp_r <= 1'b0;
      pend_r <= 1'b0;
      en_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r <= go_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_max_r <= cfg_max_nxt;
      cfg_hl_r <= cfg_hl_nxt;
      cfg_sup_r <= cfg_sup_nxt;
      cfg_reuse_r <= cfg_reuse_nxt;
      cfg_flap_r <= cfg_flap_nxt;
      cfg_mon_r <= cfg_mon_nxt;
      run_max_r <= run_max_nxt;
      run_hl_r <= run_hl_nxt;
      run_sup_r <= run_sup_nxt;
      run_reuse_r <= run_reuse_nxt;
      run_flap_r <= run_flap_nxt;
      run_mon_r <= run_mon_nxt;
      actual_r <= actual_nxt;
      shown_r <= shown_nxt;
      pen_r <= pen_nxt;
      ceil_r <= ceil_nxt;
      last_r <= last_nxt;
      deadline_r <= deadline_nxt;
      damp_r <= damp_nxt;
      pend_r <= pend_nxt;
      en_r <= en_nxt;
    end
  end

  // Working and result payload registers need no reset.
  always_ff @(posedge clk) begin
    hl_us_r <= hl_us_nxt;
    post_r <= post_nxt;
    now_r <= now_nxt;
    dt_r <= dt_nxt;
    t_r <= t_nxt;
    add_flap_r <= add_flap_nxt;
    ceil_mode_r <= ceil_mode_nxt;
    notify_r <= notify_nxt;
    whole_r <= whole_nxt;
    n_r <= n_nxt;
    acc_r <= acc_nxt;
    x_r <= x_nxt;
    j_r <= j_nxt;
    lf_r <= lf_nxt;
    m_r <= m_nxt;
    if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
      o_notify_r <= notify_r;
      o_adv_r <= shown_r;
      o_sup_r <= damp_r;
      o_pen_r <= pen_r;
      o_arm_r <= pend_r;
    end
  end

endmodule
